// ===== rtl/priority_thread_selector_with_wake_assert.svh =====
// assertion macros for the thread selector checker
// depends on nothing; included by the checker file only
`ifndef PRIORITY_THREAD_SELECTOR_WITH_WAKE_ASSERT_SVH
`define PRIORITY_THREAD_SELECTOR_WITH_WAKE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PTSW_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PTSW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptsw_pkg.sv =====
// types and constants shared by the thread selector modules
// no dependencies
`timescale 1ns / 1ps

package ptsw_pkg;

    // request codes
    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_UPDATE   = 2'd1;
    localparam logic [1:0] REQ_SELECT   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_BADSLOT = 2'd3;

    // run states
    localparam logic [1:0] RS_RUNNING  = 2'd0;
    localparam logic [1:0] RS_SLEEPING = 2'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  slot;
        logic [7:0]  priority_req;
        logic [1:0]  thread_state;
        logic [63:0] wake_time;
        logic [63:0] context_value;
        logic [63:0] uptime;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  selected_slot;
        logic [63:0] next_context;
        logic [7:0]  assigned_slot;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_CTXW,
        S_RESULT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       do_register;
        logic       do_update;
        logic       sel_start;
        logic       scan_issue;
        logic       fetch_ctx;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_sel;
        logic       out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] req_type;
        logic       full;
        logic       empty;
        logic       bad_slot;
        logic       scan_last;
        logic       out_free;
    } t_dp_sts;

endpackage

// ===== rtl/ptsw_datapath.sv =====
// thread table memories, scan pipeline, result and output registers
// depends on ptsw_pkg
`timescale 1ns / 1ps

module ptsw_datapath #(
    parameter int MAX_THREADS   = 256,
    parameter int PRIORITY_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptsw_pkg::t_in_item i_in_item,
    input  ptsw_pkg::t_dp_cmd  i_cmd,
    output ptsw_pkg::t_dp_sts  o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ptsw_pkg::t_out_item o_out_item
);

    localparam int IDX_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);

    // captured item and control registers
    ptsw_pkg::t_in_item  r_item;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_cur;
    logic [IDX_W-1:0]    r_scan_idx;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [IDX_W-1:0]    r_best;
    logic [PRIORITY_BITS-1:0] r_best_prio;
    ptsw_pkg::t_out_item r_res;
    logic                r_out_vld;
    ptsw_pkg::t_out_item r_out;

    // thread table memories, undefined until written
    logic [1:0]               r_rs_mem   [MAX_THREADS];
    logic [PRIORITY_BITS-1:0] r_prio_mem [MAX_THREADS];
    logic [63:0]              r_wake_mem [MAX_THREADS];
    logic [63:0]              r_ctx_mem  [MAX_THREADS];

    logic [1:0]               r_rd_rs;
    logic [PRIORITY_BITS-1:0] r_rd_prio;
    logic [63:0]              r_rd_wake;
    logic [63:0]              r_rd_ctx;

    logic [IDX_W-1:0] w_cnt_idx;
    logic [IDX_W-1:0] w_upd_idx;
    logic             w_wake;
    logic [1:0]       w_rs_eff;
    logic             w_rs_we;
    logic [IDX_W-1:0] w_rs_addr;
    logic [1:0]       w_rs_data;
    logic             w_ctx_we;
    logic [IDX_W-1:0] w_ctx_addr;
    logic [63:0]      w_ctx_data;
    logic             w_save;

    assign w_cnt_idx = IDX_W'(r_count);
    assign w_upd_idx = IDX_W'(r_item.slot);

    // wake check on the entry just read
    assign w_wake   = (r_rd_rs == ptsw_pkg::RS_SLEEPING) && (r_item.uptime >= r_rd_wake);
    assign w_rs_eff = w_wake ? ptsw_pkg::RS_RUNNING : r_rd_rs;

    // run state write port: register, update or wake write-back
    always_comb begin
        w_rs_we   = 1'b0;
        w_rs_addr = w_cnt_idx;
        w_rs_data = r_item.thread_state;
        if (i_cmd.do_register) begin
            w_rs_we = 1'b1;
        end else if (i_cmd.do_update) begin
            w_rs_we   = 1'b1;
            w_rs_addr = w_upd_idx;
        end else if (r_rd_vld && w_wake) begin
            w_rs_we   = 1'b1;
            w_rs_addr = r_rd_idx;
            w_rs_data = ptsw_pkg::RS_RUNNING;
        end
    end

    // context write port: initial value on register, outgoing save on select
    assign w_save = i_cmd.sel_start && (r_item.context_value != 64'd0)
                    && (CNT_W'(r_cur) < r_count);

    always_comb begin
        w_ctx_we   = i_cmd.do_register || w_save;
        w_ctx_addr = i_cmd.do_register ? w_cnt_idx : r_cur;
        w_ctx_data = r_item.context_value;
    end

    // run state memory
    always_ff @(posedge i_clk) begin
        if (w_rs_we) begin
            r_rs_mem[w_rs_addr] <= w_rs_data;
        end
        r_rd_rs <= r_rs_mem[r_scan_idx];
    end

    // priority and wake time memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_register || i_cmd.do_update) begin
            r_prio_mem[i_cmd.do_register ? w_cnt_idx : w_upd_idx] <=
                PRIORITY_BITS'(r_item.priority_req);
            r_wake_mem[i_cmd.do_register ? w_cnt_idx : w_upd_idx] <= r_item.wake_time;
        end
        r_rd_prio <= r_prio_mem[r_scan_idx];
        r_rd_wake <= r_wake_mem[r_scan_idx];
    end

    // context memory, read at the current best
    always_ff @(posedge i_clk) begin
        if (w_ctx_we) begin
            r_ctx_mem[w_ctx_addr] <= w_ctx_data;
        end
        r_rd_ctx <= r_ctx_mem[r_best];
    end

    // item capture and scan payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.sel_start) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_issue) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
        r_rd_idx <= r_scan_idx;
        // best so far starts at slot 0 whatever its state
        if (r_rd_vld) begin
            if (r_rd_idx == '0) begin
                r_best      <= '0;
                r_best_prio <= r_rd_prio;
            end else if (w_rs_eff == ptsw_pkg::RS_RUNNING && r_rd_prio > r_best_prio) begin
                r_best      <= r_rd_idx;
                r_best_prio <= r_rd_prio;
            end
        end
        // pending result
        if (i_cmd.res_set) begin
            r_res.status        <= i_cmd.res_status;
            r_res.selected_slot <= 8'd0;
            r_res.next_context  <= 64'd0;
            r_res.assigned_slot <= i_cmd.do_register ? 8'(r_count) : 8'd0;
        end else if (i_cmd.res_sel) begin
            r_res.status        <= ptsw_pkg::STAT_OK;
            r_res.selected_slot <= 8'(r_best);
            r_res.next_context  <= r_rd_ctx;
            r_res.assigned_slot <= 8'd0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cur     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.do_register) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.fetch_ctx) begin
                r_cur <= r_best;
            end
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // status toward the controller
    always_comb begin
        o_sts.req_type  = r_item.req_type;
        o_sts.full      = (r_count == CNT_W'(MAX_THREADS));
        o_sts.empty     = (r_count == '0);
        o_sts.bad_slot  = (32'(r_item.slot) >= 32'(r_count));
        o_sts.scan_last = (CNT_W'(r_scan_idx) == r_count - CNT_W'(1));
        o_sts.out_free  = !r_out_vld || i_out_ready;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/ptsw_ctrl.sv =====
// controller state machine for the thread selector
// depends on ptsw_pkg
`timescale 1ns / 1ps

module ptsw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ptsw_pkg::t_dp_sts i_sts,
    output ptsw_pkg::t_dp_cmd o_cmd
);

    ptsw_pkg::t_state r_state;
    ptsw_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptsw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == ptsw_pkg::S_IDLE);
        unique case (r_state)
            ptsw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ptsw_pkg::S_EXEC;
                end
            end
            ptsw_pkg::S_EXEC: begin
                unique case (i_sts.req_type)
                    ptsw_pkg::REQ_REGISTER: begin
                        o_cmd.res_set = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.res_status = ptsw_pkg::STAT_FULL;
                        end else begin
                            o_cmd.do_register = 1'b1;
                            o_cmd.res_status  = ptsw_pkg::STAT_OK;
                        end
                        n_state = ptsw_pkg::S_RESULT;
                    end
                    ptsw_pkg::REQ_UPDATE: begin
                        o_cmd.res_set = 1'b1;
                        if (i_sts.bad_slot) begin
                            o_cmd.res_status = ptsw_pkg::STAT_BADSLOT;
                        end else begin
                            o_cmd.do_update  = 1'b1;
                            o_cmd.res_status = ptsw_pkg::STAT_OK;
                        end
                        n_state = ptsw_pkg::S_RESULT;
                    end
                    ptsw_pkg::REQ_SELECT: begin
                        if (i_sts.empty) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ptsw_pkg::STAT_EMPTY;
                            n_state          = ptsw_pkg::S_RESULT;
                        end else begin
                            o_cmd.sel_start = 1'b1;
                            n_state         = ptsw_pkg::S_SCAN;
                        end
                    end
                    // unknown request: dropped without a result
                    default: begin
                        n_state = ptsw_pkg::S_IDLE;
                    end
                endcase
            end
            ptsw_pkg::S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ptsw_pkg::S_DRAIN;
                end
            end
            ptsw_pkg::S_DRAIN: begin
                n_state = ptsw_pkg::S_FETCH;
            end
            ptsw_pkg::S_FETCH: begin
                o_cmd.fetch_ctx = 1'b1;
                n_state         = ptsw_pkg::S_CTXW;
            end
            ptsw_pkg::S_CTXW: begin
                o_cmd.res_sel = 1'b1;
                n_state       = ptsw_pkg::S_RESULT;
            end
            ptsw_pkg::S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ptsw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptsw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/priority_thread_selector_with_wake.sv =====
// top level of the strict priority thread selector with sleep timers
// depends on ptsw_pkg, ptsw_ctrl and ptsw_datapath
`timescale 1ns / 1ps

// Thread table of up to MAX_THREADS entries held in single-port-read memories;
// items are taken one at a time. With the output register free, a register or
// update item passes through the execute and result states before the next
// is accepted; a select item passes through execute, scan, drain, fetch,
// context write and result. The time a select takes is set by the scan that
// reads one table entry per cycle through the memory read port and writes
// woken entries back in the cycle after their read. The table needs no
// clearing pass after reset: the fill count marks which entries exist. The
// result sits in an output register, so the next item is accepted while it
// waits to be taken.

module priority_thread_selector_with_wake #(
    parameter int MAX_THREADS   = 256,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ptsw_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ptsw_pkg::t_out_item o_out_item
);

    ptsw_pkg::t_dp_cmd w_cmd;
    ptsw_pkg::t_dp_sts w_sts;

    // sequencer
    ptsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // tables and scan
    ptsw_datapath #(
        .MAX_THREADS   (MAX_THREADS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/ptsw_checker.sv =====
// port-level checks for the thread selector, bound to the top level
// depends on ptsw_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "priority_thread_selector_with_wake_assert.svh"

module ptsw_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input ptsw_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ptsw_pkg::t_out_item o_out_item
);

    logic w_in_acc;
    logic w_out_stall;
    logic w_out_err;
    logic w_fields_zero;
    logic w_out_asg;
    logic w_asg_only;

    // port conditions used by the checks
    assign w_in_acc      = i_in_valid && o_in_ready;
    assign w_out_stall   = o_out_valid && !i_out_ready;
    assign w_out_err     = o_out_valid && (o_out_item.status != ptsw_pkg::STAT_OK);
    assign w_fields_zero = (o_out_item.selected_slot == 8'd0)
                           && (o_out_item.next_context == 64'd0)
                           && (o_out_item.assigned_slot == 8'd0);
    assign w_out_asg     = o_out_valid && (o_out_item.assigned_slot != 8'd0);
    assign w_asg_only    = (o_out_item.status == ptsw_pkg::STAT_OK)
                           && (o_out_item.selected_slot == 8'd0)
                           && (o_out_item.next_context == 64'd0);

    // a stalled item stays offered
    `PTSW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_out_valid, "result item dropped")

    // one item at a time: no accept right after an accept
    `PTSW_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, w_in_acc, !o_in_ready, "ready after accept")

    // error results carry no slot or context
    `PTSW_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, w_out_err, w_fields_zero, "nonzero error fields")

    // an assigned slot comes only from a successful register
    `PTSW_ASSERT_SAME(a_assign_ok, i_clk, i_rst_n, w_out_asg, w_asg_only, "stray assigned slot")

endmodule

bind priority_thread_selector_with_wake ptsw_checker u_ptsw_checker (.*);

// ===== test/tb.sv =====
// self-checking testbench for the priority thread selector with sleep timers
// depends on ptsw_pkg and priority_thread_selector_with_wake
`timescale 1ns / 1ps

module tb;
    import ptsw_pkg::*;

    localparam int MAX_THREADS  = 256;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 300;
    localparam int MAX_REPORTS  = 10;

    // codes the package leaves unnamed
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [1:0] RS_BLOCKED  = 2'd2;
    localparam logic [1:0] RS_RESERVED = 2'd3;

    localparam logic [63:0] ALL_ONES = '1;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;

    // idle rates in percent, set per phase
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // long receiver hold-off request and its countdown
    bit hold_start = 1'b0;
    int hold_left = 0;

    int err_cnt = 0;
    int stall_cnt = 0;

    // predicted thread table
    logic [7:0]  prio_tbl [MAX_THREADS];
    logic [1:0]  state_tbl [MAX_THREADS];
    logic [63:0] wake_tbl [MAX_THREADS];
    logic [63:0] stack_tbl [MAX_THREADS];
    int          cur_slot = 0;
    int          thread_cnt = 0;
    logic [63:0] uptime_now = 64'd1000;

    t_out_item outcome_q [$];

    priority_thread_selector_with_wake dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // work out the result of one item, updating the predicted table
    function automatic bit compute_outcome(input t_in_item it, output t_out_item res);
        int best;
        int i;
        res = '0;
        case (it.req_type)
            REQ_REGISTER: begin
                if (thread_cnt >= MAX_THREADS) begin
                    res.status = STAT_FULL;
                end else begin
                    prio_tbl[thread_cnt]  = it.priority_req;
                    state_tbl[thread_cnt] = it.thread_state;
                    wake_tbl[thread_cnt]  = it.wake_time;
                    stack_tbl[thread_cnt] = it.context_value;
                    res.status        = STAT_OK;
                    res.assigned_slot = 8'(thread_cnt);
                    thread_cnt++;
                end
                return 1'b1;
            end
            REQ_UPDATE: begin
                if (int'(it.slot) >= thread_cnt) begin
                    res.status = STAT_BADSLOT;
                end else begin
                    prio_tbl[it.slot]  = it.priority_req;
                    state_tbl[it.slot] = it.thread_state;
                    wake_tbl[it.slot]  = it.wake_time;
                    res.status = STAT_OK;
                end
                return 1'b1;
            end
            REQ_SELECT: begin
                if (thread_cnt == 0) begin
                    res.status = STAT_EMPTY;
                    return 1'b1;
                end
                if (it.context_value != 64'd0 && cur_slot < thread_cnt)
                    stack_tbl[cur_slot] = it.context_value;
                best = 0;
                for (i = 0; i < thread_cnt; i++) begin
                    if (state_tbl[i] == RS_SLEEPING && it.uptime >= wake_tbl[i])
                        state_tbl[i] = RS_RUNNING;
                    if (prio_tbl[i] > prio_tbl[best] && state_tbl[i] == RS_RUNNING)
                        best = i;
                end
                cur_slot = best;
                res.status        = STAT_OK;
                res.selected_slot = 8'(best);
                res.next_context  = stack_tbl[best];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_in_item make_item(input logic [1:0] req, input logic [7:0] slot,
                                           input logic [7:0] prio, input logic [1:0] st,
                                           input logic [63:0] wake, input logic [63:0] ctx,
                                           input logic [63:0] up);
        t_in_item it;
        it.req_type      = req;
        it.slot          = slot;
        it.priority_req  = prio;
        it.thread_state  = st;
        it.wake_time     = wake;
        it.context_value = ctx;
        it.uptime        = up;
        return it;
    endfunction

    function automatic t_in_item rand_fields();
        return make_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 2'($urandom_range(3)),
                         rand64(), rand64(), rand64());
    endfunction

    // priorities bunched on a few values so ties happen often
    function automatic logic [7:0] pick_priority();
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(3) * 64);
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [1:0] pick_state();
        int r;
        r = $urandom_range(99);
        if (r < 45) return RS_RUNNING;
        if (r < 85) return RS_SLEEPING;
        if (r < 95) return RS_BLOCKED;
        return RS_RESERVED;
    endfunction

    // wake times mostly a little ahead of the running uptime
    function automatic logic [63:0] pick_wake();
        int r;
        r = $urandom_range(9);
        if (r == 0) return rand64();
        if (r == 1) return uptime_now - 64'($urandom_range(50));
        return uptime_now + 64'($urandom_range(300));
    endfunction

    // offer one item and hold it until accepted; valid stays high afterwards
    task automatic send_item(input t_in_item it);
        t_out_item res;
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        if (compute_outcome(it, res))
            outcome_q.push_back(res);
    endtask

    // stop offering and wait for every predicted result
    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outcome_q.size() != 0);
    endtask

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_start) begin
            hold_left  = LONG_HOLD;
            hold_start = 1'b0;
        end
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // compare each result with the oldest prediction
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (outcome_q.size() == 0) begin
                if (err_cnt < MAX_REPORTS)
                    $display("unexpected item: st=%0d sel=%0d ctx=%h asg=%0d",
                             out_item.status, out_item.selected_slot,
                             out_item.next_context, out_item.assigned_slot);
                err_cnt++;
            end else begin
                want = outcome_q.pop_front();
                if (out_item.status !== want.status ||
                    out_item.selected_slot !== want.selected_slot ||
                    out_item.next_context !== want.next_context ||
                    out_item.assigned_slot !== want.assigned_slot) begin
                    if (err_cnt < MAX_REPORTS)
                        $display("mismatch: exp st=%0d sel=%0d ctx=%h asg=%0d,",
                                 want.status, want.selected_slot, want.next_context,
                                 want.assigned_slot,
                                 " got st=%0d sel=%0d ctx=%h asg=%0d",
                                 out_item.status, out_item.selected_slot,
                                 out_item.next_context, out_item.assigned_slot);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // select and update on an empty table, and an unknown request
    task automatic test_empty_table();
        send_item(make_item(REQ_SELECT, 8'd0, 8'd0, RS_RUNNING, 64'd0, 64'hdead, 64'd5));
        send_item(make_item(REQ_UPDATE, 8'd0, 8'd9, RS_RUNNING, 64'd0, 64'd0, 64'd0));
        send_item(make_item(REQ_UPDATE, 8'd255, 8'd255, RS_SLEEPING, ALL_ONES, 64'd0, 64'd0));
        send_item(make_item(REQ_UNKNOWN, 8'd1, 8'd1, RS_RUNNING, 64'd0, 64'd7, 64'd0));
        wait_drain();
    endtask

    // ties, wake boundary, context save rules, non-runnable slot 0, bad slot
    task automatic test_scheduling_rules();
        send_item(make_item(REQ_REGISTER, 8'd0, 8'd0, RS_RUNNING, 64'd0, 64'h1000, 64'd0));
        send_item(make_item(REQ_REGISTER, 8'd0, 8'd255, RS_RUNNING, ALL_ONES, ALL_ONES, 64'd0));
        send_item(make_item(REQ_REGISTER, 8'd0, 8'd255, RS_RUNNING, 64'd0, 64'h2000, 64'd0));
        send_item(make_item(REQ_REGISTER, 8'd0, 8'd128, RS_SLEEPING, 64'd1000, 64'h3000, 64'd0));
        send_item(make_item(REQ_REGISTER, 8'd0, 8'd250, RS_BLOCKED, 64'd0, 64'h4000, 64'd0));
        send_item(make_item(REQ_REGISTER, 8'd0, 8'd254, RS_RESERVED, 64'd0, 64'h5000, 64'd0));
        // context word zero is not saved
        send_item(make_item(REQ_SELECT, 8'd0, 8'd0, RS_RUNNING, 64'd0, 64'd0, 64'd0));
        send_item(make_item(REQ_UPDATE, 8'd1, 8'd255, RS_SLEEPING, 64'd1000, 64'd0, 64'd0));
        send_item(make_item(REQ_UPDATE, 8'd2, 8'd255, RS_SLEEPING, ALL_ONES, 64'd0, 64'd0));
        // one below the wake time, then exactly at it, then the top uptime
        send_item(make_item(REQ_SELECT, 8'd0, 8'd0, RS_RUNNING, 64'd0, 64'haaaa, 64'd999));
        send_item(make_item(REQ_SELECT, 8'd0, 8'd0, RS_RUNNING, 64'd0, 64'd0, 64'd1000));
        send_item(make_item(REQ_SELECT, 8'd0, 8'd0, RS_RUNNING, 64'd0, 64'hbbbb, ALL_ONES));
        // nothing runnable: slot 0 wins whatever its state
        send_item(make_item(REQ_UPDATE, 8'd0, 8'd0, RS_BLOCKED, 64'd0, 64'd0, 64'd0));
        send_item(make_item(REQ_UPDATE, 8'd1, 8'd255, RS_BLOCKED, 64'd0, 64'd0, 64'd0));
        send_item(make_item(REQ_UPDATE, 8'd2, 8'd255, RS_BLOCKED, 64'd0, 64'd0, 64'd0));
        send_item(make_item(REQ_UPDATE, 8'd3, 8'd128, RS_BLOCKED, 64'd0, 64'd0, 64'd0));
        send_item(make_item(REQ_SELECT, 8'd0, 8'd0, RS_RUNNING, 64'd0, 64'hcccc, ALL_ONES));
        // slot equal to the entry count is not registered
        send_item(make_item(REQ_UPDATE, 8'd6, 8'd1, RS_RUNNING, 64'd0, 64'd0, 64'd0));
        send_item(make_item(REQ_UPDATE, 8'd3, 8'd255, RS_RUNNING, 64'd0, 64'd0, 64'd0));
        send_item(make_item(REQ_SELECT, 8'd0, 8'd0, RS_RUNNING, 64'd0, 64'd0, 64'd0));
        wait_drain();
    endtask

    // random mix of register, update and select on a small table, plus noise
    task automatic test_random_traffic(input int n_items);
        t_in_item it;
        int done;
        int pick;
        done = 0;
        while (done < n_items) begin
            it = rand_fields();
            pick = $urandom_range(99);
            if (pick < 3) begin
                it.req_type = REQ_UNKNOWN;
            end else if (thread_cnt == 0 || (pick < 15 && thread_cnt < 40)) begin
                it.req_type     = REQ_REGISTER;
                it.priority_req = pick_priority();
                it.thread_state = pick_state();
                it.wake_time    = pick_wake();
            end else if (pick < 55) begin
                it.req_type     = REQ_UPDATE;
                if ($urandom_range(9) != 0)
                    it.slot = 8'($urandom_range(thread_cnt - 1));
                it.priority_req = pick_priority();
                it.thread_state = pick_state();
                it.wake_time    = pick_wake();
            end else begin
                it.req_type = REQ_SELECT;
                uptime_now  = uptime_now + 64'($urandom_range(40));
                if ($urandom_range(6) != 0)
                    it.uptime = uptime_now;
                if ($urandom_range(3) == 0)
                    it.context_value = 64'd0;
            end
            send_item(it);
            if (it.req_type != REQ_UNKNOWN)
                done++;
        end
        wait_drain();
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_backpressure();
        hold_start = 1'b1;
        test_random_traffic(24);
    endtask

    // fill the table, overflow it, then schedule across all entries
    task automatic test_full_table();
        t_in_item it;
        int i;
        while (thread_cnt < MAX_THREADS) begin
            it = rand_fields();
            it.req_type     = REQ_REGISTER;
            it.priority_req = pick_priority();
            it.thread_state = pick_state();
            it.wake_time    = pick_wake();
            send_item(it);
        end
        for (i = 0; i < 2; i++) begin
            it = rand_fields();
            it.req_type = REQ_REGISTER;
            send_item(it);
        end
        send_item(make_item(REQ_UPDATE, 8'd255, 8'd255, RS_SLEEPING, uptime_now + 64'd20,
                            64'd0, 64'd0));
        for (i = 0; i < 6; i++) begin
            it = rand_fields();
            it.req_type = REQ_SELECT;
            uptime_now  = uptime_now + 64'($urandom_range(10));
            it.uptime   = uptime_now;
            send_item(it);
        end
        send_item(make_item(REQ_SELECT, 8'd0, 8'd0, RS_RUNNING, 64'd0, 64'h1234, ALL_ONES));
        wait_drain();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 8;
        rx_idle_pct = 56;
        test_empty_table();
        test_scheduling_rules();
        test_random_traffic(45);
        tx_idle_pct = 56;
        rx_idle_pct = 8;
        test_random_traffic(45);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(50);

        test_backpressure();
        test_full_table();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && outcome_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== priority_thread_selector_with_wake.f =====
+incdir+rtl
rtl/ptsw_pkg.sv
rtl/ptsw_datapath.sv
rtl/ptsw_ctrl.sv
rtl/priority_thread_selector_with_wake.sv
rtl/ptsw_checker.sv
test/tb.sv
